### src/uvsg_pkg.sv
// ----------------------------------------------------------------------------
// uvsg_pkg
// Shared constants, types and helpers of the sphere vertex generator.
// ----------------------------------------------------------------------------
package uvsg_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int MAX_DIVISIONS_DEF = 256;

    localparam int CNT_W  = 9;
    localparam int IDX_W  = 8;
    localparam int RAD_W  = 16;
    localparam int POS_W  = 17;
    localparam int NRM_W  = 16;
    localparam int VN_W   = 16;
    localparam int DEN_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int FRONT_STAGES = 1;
    localparam int SIN_STAGES   = 7;
    localparam int COMP_STAGES  = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RING_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_RADIUS = 2'd2;

    localparam logic [CNT_W-1:0] RING_COUNT_RST    = 9'd16;
    localparam logic [CNT_W-1:0] SECTOR_COUNT_RST  = 9'd32;
    localparam logic [RAD_W-1:0] SPHERE_RADIUS_RST = 16'd256;

    // taylor terms of sin(pi/2*u), q30
    localparam logic [30:0] SIN_C0 = 31'd1686629713;
    localparam logic [30:0] SIN_C1 = 31'd693598669;
    localparam logic [30:0] SIN_C2 = 31'd85569309;
    localparam logic [30:0] SIN_C3 = 31'd5026997;
    localparam logic [30:0] SIN_C4 = 31'd172272;

    localparam logic signed [NRM_W-1:0] NEG_ONE_Q15 = 16'sh8000;

    typedef logic [NRM_W-1:0] q15_t;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c,
                                                     input logic [CNT_W-1:0] maxc);
        logic [CNT_W-1:0] r;
        r = c;
        if (c < 9'd2) r = 9'd2;
        else if (c > maxc) r = maxc;
        return r;
    endfunction

endpackage

### src/uvsg_front.sv
// ----------------------------------------------------------------------------
// uvsg_front
// Count clamping, index saturation, dividend setup and vertex number.
// ----------------------------------------------------------------------------
module uvsg_front #(
    parameter int ANGLE_BITS    = uvsg_pkg::ANGLE_BITS_DEF,
    parameter int MAX_DIVISIONS = uvsg_pkg::MAX_DIVISIONS_DEF,
    parameter int DW            = ANGLE_BITS + 8
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [uvsg_pkg::CNT_W-1:0]  ring_count,
    input  logic [uvsg_pkg::CNT_W-1:0]  sector_count,
    input  logic [uvsg_pkg::IDX_W-1:0]  ring_index,
    input  logic [uvsg_pkg::IDX_W-1:0]  sector_index,
    output logic [DW-1:0]               pol_num,
    output logic [DW-1:0]               az_num,
    output logic [uvsg_pkg::DEN_W-1:0]  pol_den,
    output logic [uvsg_pkg::DEN_W-1:0]  az_den,
    output logic [uvsg_pkg::VN_W-1:0]   vertex_number
);
    import uvsg_pkg::*;

    logic [CNT_W-1:0] rc, sc, rd9, sd9;
    logic [IDX_W-1:0] ri, si;
    logic [16:0]      vn_full;

    logic [DW-1:0]    pol_num_reg, az_num_reg;
    logic [DEN_W-1:0] pol_den_reg, az_den_reg;
    logic [VN_W-1:0]  vn_reg;

    always_comb begin
        rc  = clamp_count(ring_count, CNT_W'(MAX_DIVISIONS));
        sc  = clamp_count(sector_count, CNT_W'(MAX_DIVISIONS));
        rd9 = rc - 9'd1;
        sd9 = sc - 9'd1;
        ri  = ({1'b0, ring_index} > rd9) ? rd9[IDX_W-1:0] : ring_index;
        si  = ({1'b0, sector_index} > sd9) ? sd9[IDX_W-1:0] : sector_index;
        vn_full = 17'(ri) * 17'(sc) + 17'(si);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pol_num_reg <= (DW'(ri) << (ANGLE_BITS - 1)) + DW'(rd9[DEN_W-1:1]);
            az_num_reg  <= (DW'(si) << ANGLE_BITS) + DW'(sd9[DEN_W-1:1]);
            pol_den_reg <= rd9[DEN_W-1:0];
            az_den_reg  <= sd9[DEN_W-1:0];
            vn_reg      <= vn_full[VN_W-1:0];
        end
    end

    assign pol_num       = pol_num_reg;
    assign az_num        = az_num_reg;
    assign pol_den       = pol_den_reg;
    assign az_den        = az_den_reg;
    assign vertex_number = vn_reg;

endmodule

### src/uvsg_div.sv
// ----------------------------------------------------------------------------
// uvsg_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module uvsg_div #(
    parameter int DW = uvsg_pkg::ANGLE_BITS_DEF + 8
) (
    input  logic                        aclk,
    input  logic [DW-1:0]               en,
    input  logic [DW-1:0]               num,
    input  logic [uvsg_pkg::DEN_W-1:0]  den,
    output logic [DW-1:0]               quot
);
    import uvsg_pkg::*;

    logic [DW-1:0]    num_reg  [DW];
    logic [DW-1:0]    quot_reg [DW];
    logic [DEN_W-1:0] rem_reg  [DW];
    logic [DEN_W-1:0] den_reg  [DW];

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic [DW-1:0]    num_in, quot_in, quot_next;
        logic [DEN_W-1:0] rem_in, den_in, rem_next;
        logic [DEN_W:0]   trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign num_in  = num;
            assign quot_in = '0;
            assign rem_in  = '0;
            assign den_in  = den;
        end else begin : g_rest
            assign num_in  = num_reg[k-1];
            assign quot_in = quot_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
        end

        always_comb begin
            trial = {rem_in, num_in[DW-1-k]};
            ge    = trial >= {1'b0, den_in};
            rem_next = ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
            quot_next = quot_in;
            quot_next[DW-1-k] = ge;
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                num_reg[k]  <= num_in;
                quot_reg[k] <= quot_next;
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in;
            end
        end
    end

    assign quot = quot_reg[DW-1];

endmodule

### src/uvsg_sin.sv
// ----------------------------------------------------------------------------
// uvsg_sin
// Pipelined q15 sine of a phase, quarter-wave polynomial in horner form.
// ----------------------------------------------------------------------------
module uvsg_sin #(
    parameter int ANGLE_BITS = uvsg_pkg::ANGLE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic [uvsg_pkg::SIN_STAGES-1:0]    en,
    input  logic [ANGLE_BITS-1:0]              phase,
    output logic signed [uvsg_pkg::NRM_W-1:0]  sine
);
    import uvsg_pkg::*;

    localparam logic [ANGLE_BITS-2:0] QUARTER = (ANGLE_BITS-1)'(1) << (ANGLE_BITS - 2);

    logic [1:0]            quad;
    logic [ANGLE_BITS-2:0] qq;
    logic [30:0]           u_next, w_next, p_c_next, p_d_next, p_e_next, p_f_next;
    logic [61:0]           prod_b, prod_c, prod_d, prod_e, prod_f, prod_g;
    logic [31:0]           s_round;
    logic [16:0]           r_mag;
    logic [14:0]           r_cap;

    logic [30:0] u_a_reg, u_b_reg, u_c_reg, u_d_reg, u_e_reg, u_f_reg;
    logic [30:0] w_b_reg, w_c_reg, w_d_reg, w_e_reg;
    logic [30:0] p_c_reg, p_d_reg, p_e_reg, p_f_reg;
    logic        neg_a_reg, neg_b_reg, neg_c_reg, neg_d_reg, neg_e_reg, neg_f_reg;
    logic signed [NRM_W-1:0] sine_reg;

    always_comb begin
        quad   = phase[ANGLE_BITS-1:ANGLE_BITS-2];
        qq     = quad[0] ? QUARTER - {1'b0, phase[ANGLE_BITS-3:0]}
                         : {1'b0, phase[ANGLE_BITS-3:0]};
        u_next = 31'(qq) << (32 - ANGLE_BITS);

        prod_b = 62'(u_a_reg) * 62'(u_a_reg);
        w_next = 31'(prod_b >> 30);

        prod_c   = 62'(w_b_reg) * 62'(SIN_C4);
        p_c_next = SIN_C3 - 31'(prod_c >> 30);
        prod_d   = 62'(w_c_reg) * 62'(p_c_reg);
        p_d_next = SIN_C2 - 31'(prod_d >> 30);
        prod_e   = 62'(w_d_reg) * 62'(p_d_reg);
        p_e_next = SIN_C1 - 31'(prod_e >> 30);
        prod_f   = 62'(w_e_reg) * 62'(p_e_reg);
        p_f_next = SIN_C0 - 31'(prod_f >> 30);

        prod_g  = 62'(u_f_reg) * 62'(p_f_reg);
        s_round = 32'(prod_g >> 30) + 32'd16384;
        r_mag   = 17'(s_round >> 15);
        r_cap   = (r_mag > 17'd32767) ? 15'h7fff : r_mag[14:0];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            u_a_reg   <= u_next;
            neg_a_reg <= quad[1];
        end
        if (en[1]) begin
            u_b_reg   <= u_a_reg;
            w_b_reg   <= w_next;
            neg_b_reg <= neg_a_reg;
        end
        if (en[2]) begin
            u_c_reg   <= u_b_reg;
            w_c_reg   <= w_b_reg;
            p_c_reg   <= p_c_next;
            neg_c_reg <= neg_b_reg;
        end
        if (en[3]) begin
            u_d_reg   <= u_c_reg;
            w_d_reg   <= w_c_reg;
            p_d_reg   <= p_d_next;
            neg_d_reg <= neg_c_reg;
        end
        if (en[4]) begin
            u_e_reg   <= u_d_reg;
            w_e_reg   <= w_d_reg;
            p_e_reg   <= p_e_next;
            neg_e_reg <= neg_d_reg;
        end
        if (en[5]) begin
            u_f_reg   <= u_e_reg;
            p_f_reg   <= p_f_next;
            neg_f_reg <= neg_e_reg;
        end
        if (en[6]) begin
            sine_reg <= neg_f_reg ? -$signed({1'b0, r_cap}) : $signed({1'b0, r_cap});
        end
    end

    assign sine = sine_reg;

endmodule

### src/uvsg_comp.sv
// ----------------------------------------------------------------------------
// uvsg_comp
// One vertex component: q30 direction product, scaled position and normal.
// ----------------------------------------------------------------------------
module uvsg_comp (
    input  logic                               aclk,
    input  logic [uvsg_pkg::COMP_STAGES-1:0]   en,
    input  logic signed [uvsg_pkg::NRM_W-1:0]  fac_a,
    input  logic signed [uvsg_pkg::NRM_W-1:0]  fac_b,
    input  logic [uvsg_pkg::RAD_W-1:0]         radius,
    output logic signed [uvsg_pkg::POS_W-1:0]  pos,
    output logic signed [uvsg_pkg::NRM_W-1:0]  nrm
);
    import uvsg_pkg::*;

    logic signed [31:0] prod_next;
    logic [31:0]        mag_full;
    logic [29:0]        mag;
    logic [45:0]        scaled_next;
    logic [30:0]        nm_sum;
    logic [15:0]        nm_raw;
    logic [14:0]        nm_next;
    logic [45:0]        pm_sum;
    logic [POS_W-1:0]   pm;

    logic signed [31:0] prod_reg;
    logic [45:0]        scaled_reg;
    logic [14:0]        nm_reg;
    logic               neg_reg, zero_reg;
    logic signed [POS_W-1:0] pos_reg;
    logic signed [NRM_W-1:0] nrm_reg;

    always_comb begin
        prod_next   = 32'(fac_a) * 32'(fac_b);
        mag_full    = prod_reg[31] ? 32'(-prod_reg) : 32'(prod_reg);
        mag         = mag_full[29:0];
        scaled_next = 46'(radius) * 46'(mag);
        nm_sum      = 31'(mag) + 31'd16384;
        nm_raw      = 16'(nm_sum >> 15);
        nm_next     = (nm_raw > 16'd32767) ? 15'h7fff : nm_raw[14:0];
        pm_sum      = scaled_reg + (46'd1 << 29);
        pm          = POS_W'(pm_sum >> 30);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            prod_reg <= prod_next;
        end
        if (en[1]) begin
            scaled_reg <= scaled_next;
            nm_reg     <= nm_next;
            neg_reg    <= prod_reg[31];
            zero_reg   <= (radius == '0);
        end
        if (en[2]) begin
            if (zero_reg) begin
                pos_reg <= '0;
                nrm_reg <= '0;
            end else if (neg_reg) begin
                pos_reg <= $signed(POS_W'(0) - pm);
                nrm_reg <= -$signed({1'b0, nm_reg});
            end else begin
                pos_reg <= $signed(pm);
                nrm_reg <= $signed({1'b0, nm_reg});
            end
        end
    end

    assign pos = pos_reg;
    assign nrm = nrm_reg;

endmodule

### src/uv_sphere_vertex_generator_unit.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_unit
// Latitude-longitude sphere vertex generator, fully pipelined.
// ----------------------------------------------------------------------------
// A request on the s_ channel carries a ring index and a sector index; each
// gives one vertex on the m_ channel: position scaled by the radius (q.8),
// unit normal (q1.15) and the linear vertex number. Both channels use
// valid/ready. Ring count, sector count and radius are set through the cfg
// write port (cfg_we, cfg_index, cfg_wdata) while no request is in flight.
// The pipeline has one setup stage, one stage per quotient bit of the two
// angle dividers, seven stages of the sine polynomial and three of the
// component multiply and rounding. Throughput is one vertex per cycle while
// the receiver accepts. Valid bits travel with each stage and a stage loads
// whenever it or some stage after it is empty, so a stalled receiver first
// fills the bubbles, then holds everything; nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults (16 rings,
// 32 sectors, radius 1.0).
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_unit #(
    parameter int ANGLE_BITS    = uvsg_pkg::ANGLE_BITS_DEF,
    parameter int MAX_DIVISIONS = uvsg_pkg::MAX_DIVISIONS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [uvsg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [uvsg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [uvsg_pkg::IDX_W-1:0]           s_ring_index,
    input  logic [uvsg_pkg::IDX_W-1:0]           s_sector_index,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [uvsg_pkg::POS_W-1:0]    m_pos_x,
    output logic signed [uvsg_pkg::POS_W-1:0]    m_pos_y,
    output logic signed [uvsg_pkg::POS_W-1:0]    m_pos_z,
    output logic signed [uvsg_pkg::NRM_W-1:0]    m_normal_x,
    output logic signed [uvsg_pkg::NRM_W-1:0]    m_normal_y,
    output logic signed [uvsg_pkg::NRM_W-1:0]    m_normal_z,
    output logic [uvsg_pkg::VN_W-1:0]            m_vertex_number
);
    import uvsg_pkg::*;

    localparam int DW     = ANGLE_BITS + 8;
    localparam int N      = FRONT_STAGES + DW + SIN_STAGES + COMP_STAGES;
    localparam int SIN_LO = FRONT_STAGES + DW;
    localparam int CMP_LO = SIN_LO + SIN_STAGES;
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    logic [CNT_W-1:0] ring_count_reg, sector_count_reg;
    logic [RAD_W-1:0] sphere_radius_reg;

    logic [N-1:0] valid_reg, valid_next;
    logic [N-1:0] en;
    logic [N-1:0] empty;

    logic [DW-1:0]    pol_num, az_num, pol_quot, az_quot;
    logic [DEN_W-1:0] pol_den, az_den;
    logic [VN_W-1:0]  vn_front;
    logic [VN_W-1:0]  vn_reg [N-1];
    logic [ANGLE_BITS-1:0] pol_ph, az_ph;
    q15_t sin_pol, cos_pol, sin_az, cos_az;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_count_reg    <= RING_COUNT_RST;
            sector_count_reg  <= SECTOR_COUNT_RST;
            sphere_radius_reg <= SPHERE_RADIUS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_RING_COUNT:    ring_count_reg    <= cfg_wdata[CNT_W-1:0];
                CFG_SECTOR_COUNT:  sector_count_reg  <= cfg_wdata[CNT_W-1:0];
                CFG_SPHERE_RADIUS: sphere_radius_reg <= cfg_wdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage loads when it or any later stage is empty, or the output drains
    always_comb begin
        empty = ~valid_reg;
        for (int k = 0; k < N; k++) begin
            en[k] = m_ready || ((empty >> k) != '0);
            if (k == 0) valid_next[k] = en[k] ? s_valid : valid_reg[k];
            else        valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= '0;
        else          valid_reg <= valid_next;
    end

    assign s_ready = en[0];
    assign m_valid = valid_reg[N-1];

    uvsg_front #(
        .ANGLE_BITS(ANGLE_BITS), .MAX_DIVISIONS(MAX_DIVISIONS), .DW(DW)
    ) u_front (
        .aclk(aclk), .en(en[0]),
        .ring_count(ring_count_reg), .sector_count(sector_count_reg),
        .ring_index(s_ring_index), .sector_index(s_sector_index),
        .pol_num(pol_num), .az_num(az_num),
        .pol_den(pol_den), .az_den(az_den),
        .vertex_number(vn_front)
    );

    uvsg_div #(.DW(DW)) u_div_pol (
        .aclk(aclk), .en(en[SIN_LO-1:FRONT_STAGES]),
        .num(pol_num), .den(pol_den), .quot(pol_quot)
    );

    uvsg_div #(.DW(DW)) u_div_az (
        .aclk(aclk), .en(en[SIN_LO-1:FRONT_STAGES]),
        .num(az_num), .den(az_den), .quot(az_quot)
    );

    assign pol_ph = pol_quot[ANGLE_BITS-1:0];
    assign az_ph  = az_quot[ANGLE_BITS-1:0];

    uvsg_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sin_pol (
        .aclk(aclk), .en(en[CMP_LO-1:SIN_LO]), .phase(pol_ph), .sine(sin_pol)
    );
    uvsg_sin #(.ANGLE_BITS(ANGLE_BITS)) u_cos_pol (
        .aclk(aclk), .en(en[CMP_LO-1:SIN_LO]), .phase(pol_ph + QUARTER), .sine(cos_pol)
    );
    uvsg_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sin_az (
        .aclk(aclk), .en(en[CMP_LO-1:SIN_LO]), .phase(az_ph), .sine(sin_az)
    );
    uvsg_sin #(.ANGLE_BITS(ANGLE_BITS)) u_cos_az (
        .aclk(aclk), .en(en[CMP_LO-1:SIN_LO]), .phase(az_ph + QUARTER), .sine(cos_az)
    );

    uvsg_comp u_comp_x (
        .aclk(aclk), .en(en[N-1:CMP_LO]), .fac_a(cos_az), .fac_b(sin_pol),
        .radius(sphere_radius_reg), .pos(m_pos_x), .nrm(m_normal_x)
    );

    // y = -cos(polar), taken as cos(polar) times minus one in q15
    uvsg_comp u_comp_y (
        .aclk(aclk), .en(en[N-1:CMP_LO]), .fac_a(cos_pol), .fac_b(NEG_ONE_Q15),
        .radius(sphere_radius_reg), .pos(m_pos_y), .nrm(m_normal_y)
    );

    uvsg_comp u_comp_z (
        .aclk(aclk), .en(en[N-1:CMP_LO]), .fac_a(sin_az), .fac_b(sin_pol),
        .radius(sphere_radius_reg), .pos(m_pos_z), .nrm(m_normal_z)
    );

    // vertex number rides alongside the arithmetic stages
    always_ff @(posedge aclk) begin
        if (en[1]) vn_reg[0] <= vn_front;
        for (int k = 2; k < N; k++) begin
            if (en[k]) vn_reg[k-1] <= vn_reg[k-2];
        end
    end

    assign m_vertex_number = vn_reg[N-2];

    // an empty output stage always leaves room for a new request
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[N-1] |-> s_ready)
        else $error("input stalled with empty output stage");

    // normals are capped, so the most negative code never shows up
    a_normal_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_normal_x != NEG_ONE_Q15) && (m_normal_y != NEG_ONE_Q15)
                    && (m_normal_z != NEG_ONE_Q15))
        else $error("normal component out of range");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (valid_reg == '0))
        else $error("valid bits not cleared by reset");

endmodule
